### sv/drs_pkg.sv
// drs_pkg: shared types and codes of the dependency release scoreboard
// holds request kind codes, the per-cell command codes and the token that walks the cell chain
// no dependencies
package drs_pkg;

  localparam int NODE_W = 7;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_SATISFY = 2'd1,
    KIND_ALLOW   = 2'd2,
    KIND_QUERY   = 2'd3
  } drs_kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GROW,
    OP_ADD,
    OP_SAT,
    OP_ALLOW,
    OP_QUERY
  } drs_op_t;

  typedef struct packed {
    logic              valid;
    drs_op_t           op;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] dep;
    logic [NODE_W-1:0] grow_lo;
    logic [NODE_W-1:0] grow_hi;
    logic [NODE_W-1:0] rel;
    logic              any_pend;
    logic              q_pend;
    logic              q_used;
  } drs_tok_t;

endpackage

### sv/drs_cell.sv
// drs_cell: one target node of the scoreboard, its source row plus pending and used bits
// applies the command token as it passes and hands it to the next cell
// depends on drs_pkg
module drs_cell #(
  parameter int NODES = 64,
  parameter int IDX   = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  drs_pkg::drs_tok_t tok_i,
  output drs_pkg::drs_tok_t tok_o,
  output logic              pend_o
);
  import drs_pkg::*;

  localparam int RW = (NODES > 1) ? $clog2(NODES) : 1;

  logic [NODES-1:0] row_r, row_nxt;
  logic             pend_r, pend_nxt;
  logic             used_r, used_nxt;
  drs_tok_t         tok_r, tok_nxt;

  always_comb begin
    logic [RW-1:0]    sidx;
    logic [NODES-1:0] sbit;
    logic             hit;
    logic             dhit;
    logic             grow;
    sidx     = RW'(tok_i.node - 7'd1);
    sbit     = {{(NODES-1){1'b0}}, 1'b1} << sidx;
    hit      = (int'(tok_i.node) == IDX);
    dhit     = (int'(tok_i.dep) == IDX);
    grow     = (int'(tok_i.grow_lo) < IDX) && (IDX <= int'(tok_i.grow_hi));
    tok_nxt  = tok_i;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    used_nxt = used_r;
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_GROW: begin
          if (grow) pend_nxt = 1'b1;
        end
        OP_ADD: begin
          if (grow) pend_nxt = 1'b1;
          if (dhit) begin
            pend_nxt = 1'b0;
            row_nxt  = row_r | sbit;
          end
        end
        OP_SAT: begin
          if (hit) begin
            pend_nxt = 1'b0;
            used_nxt = 1'b1;
          end
          // last remaining source gone: target becomes ready
          if ((row_r & sbit) != '0) begin
            row_nxt = row_r & ~sbit;
            if (row_nxt == '0) begin
              pend_nxt    = 1'b1;
              tok_nxt.rel = tok_i.rel + 7'd1;
            end
          end
        end
        OP_ALLOW: begin
          if (hit) used_nxt = 1'b1;
        end
        OP_QUERY: begin
          if (hit) begin
            tok_nxt.q_pend = pend_r;
            tok_nxt.q_used = used_r;
          end
        end
        default: ;
      endcase
      tok_nxt.any_pend = tok_i.any_pend | pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      pend_r      <= 1'b0;
      used_r      <= 1'b0;
      tok_r.valid <= 1'b0;
    end else if (en) begin
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
      used_r <= used_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o  = tok_r;
  assign pend_o = pend_r;

endmodule

### sv/dependency_release_scoreboard.sv
// dependency_release_scoreboard: kahn-style dependency scoreboard over nodes 1..NODES
// top level: request decode, node and resolve counters, chain of drs_cell, output register
// depends on drs_pkg and drs_cell
//
//   channel   direction  handshake             payload
//   in_       slave      in_tvalid/in_tready   tuser: kind; tdata: node, dependent
//   out_      master     out_tvalid/out_tready tdata: result flags and counts
//
// a request is decoded on acceptance against the counters and the pending bits, then a
// command token walks the row of NODES cells, one cell per cycle while the output is not
// stalled; the result is registered when the token leaves the last cell
// one request in flight at a time: in_tready rises the cycle after the result is loaded
// a stalled output freezes the whole chain and holds off new requests until it drains;
// reset clears all cell rows and counters at once
module dependency_release_scoreboard #(
  parameter int NODES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // node [6:0], dependent [13:7], zero [15:14]
  input  logic [1:0]  in_tuser,   // kind [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // accepted [0], error [1], is_pending [2], is_used [3],
                                  // released_count [10:4], resolved_total [17:11],
                                  // done_res [18], zero [23:19]
);
  import drs_pkg::*;

  localparam int RW = (NODES > 1) ? $clog2(NODES) : 1;

  // control state
  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] node_limit_r, node_limit_nxt;
  logic [NODE_W-1:0] resolved_r, resolved_nxt;
  // payload held for the result
  logic              acc_r, acc_nxt;
  logic              err_r, err_nxt;
  logic [23:0]       out_data_r, out_data_nxt;

  logic              accept;
  logic              adv;
  logic              load;
  logic [NODE_W-1:0] in_node;
  logic [NODE_W-1:0] in_dep;
  logic [NODES-1:0]  pend_vec;
  drs_tok_t          inject;
  drs_tok_t          tok [0:NODES];

  assign in_node   = in_tdata[6:0];
  assign in_dep    = in_tdata[13:7];
  // a new token may only enter while the first cell is clocked
  assign in_tready = !busy_r && adv;
  assign accept    = in_tvalid && in_tready;

  // chain holds while a finished result cannot be handed over
  assign adv  = !(out_valid_r && !out_tready);
  assign load = tok[NODES].valid && adv;

  // decode the request against the current counters and pending bits
  always_comb begin
    logic              s_ok;
    logic              t_ok;
    logic              pend_at;
    logic [NODE_W-1:0] lim;
    logic [RW-1:0]     sidx;
    s_ok    = (in_node != '0) && (int'(in_node) <= NODES);
    t_ok    = (in_dep != '0) && (int'(in_dep) <= NODES);
    sidx    = RW'(in_node - 7'd1);
    pend_at = s_ok && pend_vec[sidx];
    lim     = (in_node > in_dep) ? in_node : in_dep;

    node_limit_nxt = node_limit_r;
    resolved_nxt   = resolved_r;
    acc_nxt        = acc_r;
    err_nxt        = err_r;

    inject          = '0;
    inject.valid    = accept;
    inject.op       = OP_NONE;
    inject.node     = in_node;
    inject.dep      = in_dep;
    inject.grow_lo  = node_limit_r;
    inject.grow_hi  = node_limit_r;

    if (accept) begin
      acc_nxt = 1'b0;
      err_nxt = 1'b0;
      case (drs_kind_t'(in_tuser))
        KIND_ADD: begin
          if (s_ok && t_ok) begin
            // the node count grows even when the dependency is refused
            if (lim > node_limit_r) node_limit_nxt = lim;
            inject.grow_hi = node_limit_nxt;
            if (resolved_r != '0) begin
              inject.op = OP_GROW;
              err_nxt   = 1'b1;
            end else begin
              inject.op = OP_ADD;
              acc_nxt   = 1'b1;
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
        KIND_SATISFY: begin
          if (pend_at) begin
            inject.op    = OP_SAT;
            resolved_nxt = resolved_r + 7'd1;
            acc_nxt      = 1'b1;
          end
        end
        KIND_ALLOW: inject.op = OP_ALLOW;
        KIND_QUERY: inject.op = OP_QUERY;
        default:    inject.op = OP_NONE;
      endcase
    end
  end

  assign tok[0] = inject;

  // row of target cells, cell g holds node g+1
  for (genvar g = 0; g < NODES; g++) begin : g_cell
    drs_cell #(
      .NODES (NODES),
      .IDX   (g + 1)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1]),
      .pend_o (pend_vec[g])
    );
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      busy_nxt      = 1'b0;
      out_data_nxt  = {5'b0,
                       (resolved_r == node_limit_r) && !tok[NODES].any_pend,
                       resolved_r,
                       tok[NODES].rel,
                       tok[NODES].q_used,
                       tok[NODES].q_pend,
                       err_r,
                       acc_r};
    end
    if (accept) busy_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      node_limit_r <= '0;
      resolved_r   <= '0;
    end else begin
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      node_limit_r <= node_limit_nxt;
      resolved_r   <= resolved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // a result never both accepts and refuses
  a_acc_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("result flags accepted and error together");

  // released targets only come from a successful satisfy
  a_rel_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[10:4] != 7'd0)) |-> out_tdata[0])
    else $error("targets released without an accepted satisfy");

  // every resolved node is a known node
  a_resolved_le_limit: assert property (@(posedge clk) disable iff (!rst_n)
    resolved_r <= node_limit_r)
    else $error("resolved count exceeds node count");

endmodule
